### rtl/wzs_pkg.sv
// Shared types and constants for the per-pixel baseline z-score block.
// No dependencies; imported by wzs_div and the top level.
package wzs_pkg;

  localparam int unsigned STEPS_PER_STAGE = 4;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_SCORE = 2'd2;

  localparam logic REG_SCORE_METHOD = 1'b0;
  localparam logic REG_MIN_OBS      = 1'b1;

  localparam logic METHOD_ZSCORE = 1'b0;
  localparam logic METHOD_DIFF   = 1'b1;

  localparam logic [15:0] MIN_OBS_FLOOR = 16'd2;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [15:0]        n;
    logic signed [31:0] mean;
    logic [63:0]        m2;
  } wzs_entry_t;

  typedef struct packed {
    logic               is_score;
    logic               do_add;
    logic               do_clr;
    logic [15:0]        idx;
    logic               xvalid;
    logic signed [31:0] x;
    logic [15:0]        n;
    logic signed [31:0] mean;
    logic [63:0]        m2;
    logic               d_neg;
    logic [32:0]        ad;
  } wzs_item_t;

  typedef struct packed {
    logic [15:0]        idx;
    logic               xvalid;
    logic [15:0]        n;
    logic signed [31:0] mean;
    logic               d_neg;
    logic [32:0]        ad;
    logic               sd_zero;
  } wzs_score_t;

endpackage

### rtl/wzs_div.sv
// Pipelined restoring divider, STEPS_PER_STAGE quotient bits per stage.
// Depends on wzs_pkg; carries an opaque tag alongside each beat.
module wzs_div import wzs_pkg::*; #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 16,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] dvs_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  localparam int unsigned NS = (NW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  logic [NS-1:0] vld_q;
  logic [DW-1:0] rem_q [NS];
  logic [DW-1:0] rem_d [NS];
  logic [NW-1:0] num_q [NS];
  logic [NW-1:0] num_d [NS];
  logic [DW-1:0] dvs_q [NS];
  logic [DW-1:0] dvs_d [NS];
  logic [TW-1:0] tag_q [NS];
  logic [TW-1:0] tag_d [NS];

  always_comb begin
    logic [DW-1:0] rem;
    logic [NW-1:0] num;
    logic [DW-1:0] dvs;
    logic [DW:0]   t;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rem      = '0;
        num      = num_i;
        dvs      = dvs_i;
        tag_d[s] = tag_i;
      end else begin
        rem      = rem_q[s-1];
        num      = num_q[s-1];
        dvs      = dvs_q[s-1];
        tag_d[s] = tag_q[s-1];
      end
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        if (s * STEPS_PER_STAGE + k < NW) begin
          t = {rem, num[NW-1]};
          if (t >= {1'b0, dvs}) begin
            t   = t - {1'b0, dvs};
            rem = t[DW-1:0];
            num = {num[NW-2:0], 1'b1};
          end else begin
            rem = t[DW-1:0];
            num = {num[NW-2:0], 1'b0};
          end
        end
      end
      rem_d[s] = rem;
      num_d[s] = num;
      dvs_d[s] = dvs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        if (s == 0) begin
          vld_q[s] <= vld_i;
        end else begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        rem_q[s] <= rem_d[s];
        num_q[s] <= num_d[s];
        dvs_q[s] <= dvs_d[s];
        tag_q[s] <= tag_d[s];
      end
    end
  end

  assign vld_o = vld_q[NS-1];
  assign quo_o = num_q[NS-1];
  assign tag_o = tag_q[NS-1];

endmodule

### rtl/per_pixel_baseline_zscore_anomaly.sv
// Top level: per-pixel Welford baseline store with z-score / difference scoring.
// Depends on wzs_pkg and wzs_div (two instances).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one beat per cycle when not
//   stalled: clear, add or score for one pixel. Only score beats give an output
//   beat on out_valid_o / out_stall_i; clear, add and unused codes give none.
//   Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i), to be
//   written by the user only while the block holds no work; the block does not enforce it.
// Pipeline: store read, entry decode, shared divider, multiply and store write,
//   square root, z-score divider, output register.
// Throughput: one beat per cycle when not stalled. A beat whose pixel still has
//   a clear or add in the first ceil(64/4)+3 stages (before the store write)
//   waits until that write is done; the store has one read and one write port.
// Reset: the store is zeroed one entry per cycle, all TILE_PIXELS entries, with
//   in_stall_o high throughout; registers go to z-score and minimum 2.
// Output stall: a held output beat freezes the whole pipeline; nothing is
//   dropped or repeated.
module per_pixel_baseline_zscore_anomaly import wzs_pkg::*; #(
  parameter int unsigned TILE_PIXELS = 65536,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        pixel_index_i,
  input  logic signed [31:0] sample_i,
  input  logic               sample_valid_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        result_index_o,
  output logic signed [31:0] anomaly_o,
  output logic               anomaly_valid_o,
  output logic signed [31:0] base_mean_o,
  output logic               mean_valid_o,
  output logic [15:0]        baseline_count_o
);

  localparam int unsigned AW     = $clog2(TILE_PIXELS);
  localparam int unsigned CW     = (AW + 1 > 16) ? AW + 1 : 17;
  localparam int unsigned MW     = 33 + FRAC_BITS;
  localparam int unsigned RADW   = 64 + FRAC_BITS + (FRAC_BITS % 2);
  localparam int unsigned RW     = RADW / 2;
  localparam int unsigned D1_LAT = (64 + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned HL     = D1_LAT + 3;
  localparam int unsigned SQ_NS  = (RW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned ITW    = $bits(wzs_item_t);
  localparam int unsigned STW    = $bits(wzs_score_t);

  // config
  logic        method_q;
  logic [15:0] min_obs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q  <= METHOD_ZSCORE;
      min_obs_q <= MIN_OBS_FLOOR;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SCORE_METHOD: method_q  <= cfg_data_i[0];
        REG_MIN_OBS:      min_obs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // flow control
  logic en;
  logic out_valid_q;
  logic clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic hazard;
  logic accept;
  logic [HL-1:0] hz_v_q;
  logic [15:0]   hz_idx_q [HL];

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_busy_q || !en || hazard;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < HL; i++) begin
      if (hz_v_q[i] && hz_idx_q[i] == pixel_index_i) begin
        hazard = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hz_v_q <= '0;
    end else if (en) begin
      hz_v_q[0] <= accept && (operation_i == OP_CLEAR || operation_i == OP_ADD);
      for (int i = 1; i < HL; i++) begin
        hz_v_q[i] <= hz_v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hz_idx_q[0] <= pixel_index_i;
      for (int i = 1; i < HL; i++) begin
        hz_idx_q[i] <= hz_idx_q[i-1];
      end
    end
  end

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(TILE_PIXELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // store
  wzs_entry_t mem_q [TILE_PIXELS];
  wzs_entry_t rd_q;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  wzs_entry_t wr_data;

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (en && wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q <= mem_q[AW'(pixel_index_i)];
    end
  end

  // stage 0
  logic               s0_vld_q;
  logic [1:0]         s0_op_q;
  logic [15:0]        s0_idx_q;
  logic signed [31:0] s0_x_q;
  logic               s0_xv_q;
  logic               s0_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_op_q  <= operation_i;
      s0_idx_q <= pixel_index_i;
      s0_x_q   <= sample_i;
      s0_xv_q  <= sample_valid_i;
      s0_in_q  <= CW'(pixel_index_i) < CW'(TILE_PIXELS);
    end
  end

  // stage 1: decode entry
  wzs_entry_t ent;
  logic [32:0] d_w;
  wzs_item_t  s1_item_d;
  logic       s1_vld_q;
  wzs_item_t  s1_item_q;

  always_comb begin
    ent = s0_in_q ? rd_q : '0;
    d_w = {s0_x_q[31], s0_x_q} - {ent.mean[31], ent.mean};
    s1_item_d.is_score = s0_op_q == OP_SCORE;
    s1_item_d.do_add   = s0_op_q == OP_ADD && s0_in_q && s0_xv_q && ent.n != COUNT_MAX;
    s1_item_d.do_clr   = s0_op_q == OP_CLEAR && s0_in_q;
    s1_item_d.idx      = s0_idx_q;
    s1_item_d.xvalid   = s0_xv_q;
    s1_item_d.x        = s0_x_q;
    s1_item_d.n        = ent.n;
    s1_item_d.mean     = ent.mean;
    s1_item_d.m2       = ent.m2;
    s1_item_d.d_neg    = d_w[32];
    s1_item_d.ad       = d_w[32] ? (~d_w + 33'd1) : d_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_item_q <= s1_item_d;
    end
  end

  // shared divider: mean step for adds, M2/(n-1) for scores
  logic [63:0]    d1_num;
  logic [15:0]    d1_dvs;
  logic           d1_vld;
  logic [63:0]    d1_quo;
  logic [ITW-1:0] d1_tag;
  wzs_item_t      d1_item;

  assign d1_num = s1_item_q.do_add ? 64'(s1_item_q.ad) : s1_item_q.m2;
  assign d1_dvs = s1_item_q.do_add ? s1_item_q.n + 16'd1 : s1_item_q.n - 16'd1;

  wzs_div #(.NW(64), .DW(16), .TW(ITW)) u_div_var (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (s1_vld_q),
    .num_i (d1_num),
    .dvs_i (d1_dvs),
    .tag_i (s1_item_q),
    .vld_o (d1_vld),
    .quo_o (d1_quo),
    .tag_o (d1_tag)
  );

  assign d1_item = wzs_item_t'(d1_tag);

  // multiply stage; |x - new mean| = |d| - quotient
  logic [33:0] nm_w;
  logic [32:0] ae_w;
  logic [65:0] prod_w;
  logic        mul_vld_q;
  wzs_item_t   mul_item_q;
  logic [65:0] mul_prod_q;
  logic signed [31:0] mul_nm_q;
  logic [63:0] mul_var_q;

  always_comb begin
    nm_w = {{2{d1_item.mean[31]}}, d1_item.mean}
         + (d1_item.d_neg ? (~{1'b0, d1_quo[32:0]} + 34'd1) : {1'b0, d1_quo[32:0]});
    ae_w = d1_item.ad - d1_quo[32:0];
    prod_w = d1_item.ad * ae_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (en) begin
      mul_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_item_q <= d1_item;
      mul_prod_q <= prod_w;
      mul_nm_q   <= nm_w[31:0];
      mul_var_q  <= d1_quo;
    end
  end

  // store write
  logic [65:0] inc_w;
  logic [66:0] sum_w;

  always_comb begin
    inc_w   = mul_prod_q >> FRAC_BITS;
    sum_w   = {3'b000, mul_item_q.m2} + {1'b0, inc_w};
    wr_en   = mul_vld_q && (mul_item_q.do_add || mul_item_q.do_clr);
    wr_addr = AW'(mul_item_q.idx);
    if (mul_item_q.do_clr) begin
      wr_data = '0;
    end else begin
      wr_data.n    = mul_item_q.n + 16'd1;
      wr_data.mean = mul_nm_q;
      wr_data.m2   = (|sum_w[66:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : sum_w[63:0];
    end
  end

  // square root, STEPS_PER_STAGE root bits per stage
  wzs_score_t sq_in;
  logic [SQ_NS-1:0] sq_vld_q;
  logic [RW+1:0]    sq_rem_q  [SQ_NS];
  logic [RW+1:0]    sq_rem_d  [SQ_NS];
  logic [RW-1:0]    sq_root_q [SQ_NS];
  logic [RW-1:0]    sq_root_d [SQ_NS];
  logic [RADW-1:0]  sq_rad_q  [SQ_NS];
  logic [RADW-1:0]  sq_rad_d  [SQ_NS];
  wzs_score_t       sq_tag_q  [SQ_NS];
  wzs_score_t       sq_tag_d  [SQ_NS];

  always_comb begin
    sq_in.idx     = mul_item_q.idx;
    sq_in.xvalid  = mul_item_q.xvalid;
    sq_in.n       = mul_item_q.n;
    sq_in.mean    = mul_item_q.mean;
    sq_in.d_neg   = mul_item_q.d_neg;
    sq_in.ad      = mul_item_q.ad;
    sq_in.sd_zero = 1'b0;
  end

  always_comb begin
    logic [RW+1:0]   rem;
    logic [RW-1:0]   root;
    logic [RADW-1:0] rad;
    logic [RW+3:0]   t;
    logic [RW+3:0]   trial;
    for (int s = 0; s < SQ_NS; s++) begin
      if (s == 0) begin
        rem         = '0;
        root        = '0;
        rad         = RADW'({mul_var_q, {FRAC_BITS{1'b0}}});
        sq_tag_d[s] = sq_in;
      end else begin
        rem         = sq_rem_q[s-1];
        root        = sq_root_q[s-1];
        rad         = sq_rad_q[s-1];
        sq_tag_d[s] = sq_tag_q[s-1];
      end
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        if (s * STEPS_PER_STAGE + k < RW) begin
          t     = {rem, rad[RADW-1:RADW-2]};
          trial = (RW + 4)'({root, 2'b01});
          if (t >= trial) begin
            t    = t - trial;
            rem  = t[RW+1:0];
            root = {root[RW-2:0], 1'b1};
          end else begin
            rem  = t[RW+1:0];
            root = {root[RW-2:0], 1'b0};
          end
          rad = rad << 2;
        end
      end
      sq_rem_d[s]  = rem;
      sq_root_d[s] = root;
      sq_rad_d[s]  = rad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= '0;
    end else if (en) begin
      for (int s = 0; s < SQ_NS; s++) begin
        if (s == 0) begin
          sq_vld_q[s] <= mul_vld_q && mul_item_q.is_score;
        end else begin
          sq_vld_q[s] <= sq_vld_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < SQ_NS; s++) begin
        sq_rem_q[s]  <= sq_rem_d[s];
        sq_root_q[s] <= sq_root_d[s];
        sq_rad_q[s]  <= sq_rad_d[s];
        sq_tag_q[s]  <= sq_tag_d[s];
      end
    end
  end

  // |d| << FRAC_BITS over stddev
  wzs_score_t     d2_in;
  logic           d2_vld;
  logic [MW-1:0]  d2_quo;
  logic [STW-1:0] d2_tag;
  wzs_score_t     fin;

  always_comb begin
    d2_in         = sq_tag_q[SQ_NS-1];
    d2_in.sd_zero = sq_root_q[SQ_NS-1] == '0;
  end

  wzs_div #(.NW(MW), .DW(RW), .TW(STW)) u_div_z (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (sq_vld_q[SQ_NS-1]),
    .num_i ({sq_tag_q[SQ_NS-1].ad, {FRAC_BITS{1'b0}}}),
    .dvs_i (sq_root_q[SQ_NS-1]),
    .tag_i (d2_in),
    .vld_o (d2_vld),
    .quo_o (d2_quo),
    .tag_o (d2_tag)
  );

  assign fin = wzs_score_t'(d2_tag);

  // output stage
  function automatic logic [31:0] sat_mag(input logic neg, input logic [MW-1:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = (mag > MW'(32'h8000_0000)) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      r = (mag > MW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

  logic [15:0] min_eff;
  logic        enough;
  logic        av_w;
  logic [31:0] an_w;

  always_comb begin
    min_eff = (min_obs_q < MIN_OBS_FLOOR) ? MIN_OBS_FLOOR : min_obs_q;
    enough  = fin.xvalid && fin.n != 16'd0 && fin.n >= min_eff;
    if (method_q == METHOD_DIFF) begin
      av_w = enough;
      an_w = sat_mag(fin.d_neg, MW'(fin.ad));
    end else begin
      av_w = enough && !fin.sd_zero;
      an_w = sat_mag(fin.d_neg, d2_quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_index_o   <= fin.idx;
      anomaly_o        <= av_w ? an_w : 32'd0;
      anomaly_valid_o  <= av_w;
      base_mean_o      <= (fin.n != 16'd0) ? fin.mean : 32'sd0;
      mean_valid_o     <= fin.n != 16'd0;
      baseline_count_o <= fin.n;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/wzs_checker.sv
// Port-level checks for the per-pixel baseline z-score block.
// Bound to per_pixel_baseline_zscore_anomaly; no package dependency.
module wzs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [15:0]        result_index_o,
  input logic signed [31:0] anomaly_o,
  input logic               anomaly_valid_o,
  input logic signed [31:0] base_mean_o,
  input logic               mean_valid_o,
  input logic [15:0]        baseline_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(anomaly_o)
      && $stable(result_index_o) && $stable(baseline_count_o))
    else $error("output beat changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !anomaly_valid_o |-> anomaly_o == 32'sd0)
    else $error("invalid anomaly not zero");

  a_mean_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mean_valid_o == (baseline_count_o != 16'd0))
    else $error("mean_valid disagrees with count");

  a_empty_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mean_valid_o |-> base_mean_o == 32'sd0 && !anomaly_valid_o)
    else $error("empty entry gave mean or anomaly");

  a_min_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && anomaly_valid_o |-> baseline_count_o >= 16'd2)
    else $error("anomaly valid below two samples");

endmodule

bind per_pixel_baseline_zscore_anomaly wzs_checker u_wzs_checker (.*);
